// File: rtl/dcmt_pkg.sv
`timescale 1ns / 1ps

package dcmt_pkg;

  localparam int NUM_CHILDREN_DEF = 16;

  localparam int ID_W   = 16;
  localparam int ADDR_W = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_GOOD   = 2'd0,
    ST_EXISTS = 2'd1,
    ST_FULL   = 2'd2,
    ST_PARAM  = 2'd3
  } status_t;

  // Outcome of comparing one slot against the request.
  typedef struct packed {
    logic id_hit;
    logic addr_hit;
    logic free;
  } hit_t;

endpackage

// File: rtl/directory_child_map_table.sv
`timescale 1ns / 1ps

// Directory child map table: NUM_CHILDREN slots bind a nonzero file id to a
// nonzero storage address. Pulse start while busy is low to issue a
// transaction. Lookup and insert scan the slot memory one slot per cycle
// through its single registered read port, and busy stays high until the
// scan ends (a lookup hit or an insert that finds a duplicate ends the scan
// early); clear, a lookup of id zero, a rejected insert and the unused op
// code finish at once. The result appears on the out_ ports for
// exactly one cycle with out_strobe high, in the cycle after the scan ends,
// and the receiver cannot stall it. The table is empty after reset.
module directory_child_map_table #(
  parameter int NUM_CHILDREN = dcmt_pkg::NUM_CHILDREN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [dcmt_pkg::ID_W-1:0]   in_file_id,
  input  logic [dcmt_pkg::ADDR_W-1:0] in_target_addr,
  output logic                        out_strobe,
  output logic [dcmt_pkg::ADDR_W-1:0] out_found_addr,
  output logic [1:0]                  out_status
);
  import dcmt_pkg::*;

  localparam int IDX_W = (NUM_CHILDREN > 1) ? $clog2(NUM_CHILDREN) : 1;
  localparam int CNT_W = $clog2(NUM_CHILDREN + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHILDREN - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_CHILDREN);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic              have_free_r, have_free_nxt;
  logic [IDX_W-1:0]  free_at_r, free_at_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic [ADDR_W-1:0] out_found_addr_r, out_found_addr_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              clr, rd_en, wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [ID_W-1:0]   rd_id;
  logic [ADDR_W-1:0] rd_addr;
  hit_t              hit;
  op_t               in_op_t;

  assign in_op_t = op_t'(in_op);

  dcmt_store #(
    .NUM_CHILDREN(NUM_CHILDREN),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr),
    .rd_en   (rd_en),
    .rd_idx  (iss_cnt_r[IDX_W-1:0]),
    .rd_vld_r(rd_vld_r),
    .rd_idx_r(rd_idx_r),
    .rd_id   (rd_id),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_id   (id_r),
    .wr_addr (addr_r)
  );

  dcmt_cmp u_cmp (
    .slot_id  (rd_id),
    .slot_addr(rd_addr),
    .req_id   (id_r),
    .req_addr (addr_r),
    .hit      (hit)
  );

  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    id_nxt             = id_r;
    addr_nxt           = addr_r;
    iss_cnt_nxt        = iss_cnt_r;
    have_free_nxt      = have_free_r;
    free_at_nxt        = free_at_r;
    out_strobe_nxt     = 1'b0;
    out_found_addr_nxt = out_found_addr_r;
    out_status_nxt     = out_status_r;
    clr                = 1'b0;
    rd_en              = 1'b0;
    wr_en              = 1'b0;
    wr_idx             = free_at_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_op_t;
          id_nxt        = in_file_id;
          addr_nxt      = in_target_addr;
          iss_cnt_nxt   = '0;
          have_free_nxt = 1'b0;
          if ((in_op_t == OP_LOOKUP && in_file_id != '0) ||
              (in_op_t == OP_INSERT && in_file_id != '0 && in_target_addr != '0)) begin
            state_nxt = S_SCAN;
          end else begin
            clr                = (in_op_t == OP_CLEAR);
            out_strobe_nxt     = 1'b1;
            out_found_addr_nxt = '0;
            out_status_nxt     = (in_op_t == OP_INSERT) ? ST_PARAM : ST_GOOD;
          end
        end
      end
      S_SCAN: begin
        if (iss_cnt_r < CNT_END) begin
          rd_en       = 1'b1;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (op_r == OP_LOOKUP) begin
            if (hit.id_hit || rd_idx_r == LAST_IDX) begin
              state_nxt          = S_IDLE;
              out_strobe_nxt     = 1'b1;
              out_found_addr_nxt = hit.id_hit ? rd_addr : '0;
              out_status_nxt     = ST_GOOD;
            end
          end else begin
            if (hit.id_hit || hit.addr_hit) begin
              state_nxt          = S_IDLE;
              out_strobe_nxt     = 1'b1;
              out_found_addr_nxt = '0;
              out_status_nxt     = ST_EXISTS;
            end else begin
              if (hit.free && !have_free_r) begin
                have_free_nxt = 1'b1;
                free_at_nxt   = rd_idx_r;
              end
              if (rd_idx_r == LAST_IDX) begin
                state_nxt          = S_IDLE;
                out_strobe_nxt     = 1'b1;
                out_found_addr_nxt = '0;
                wr_en              = have_free_r || hit.free;
                wr_idx             = have_free_r ? free_at_r : rd_idx_r;
                out_status_nxt     = (have_free_r || hit.free) ? ST_GOOD : ST_FULL;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    op_r             <= op_nxt;
    id_r             <= id_nxt;
    addr_r           <= addr_nxt;
    iss_cnt_r        <= iss_cnt_nxt;
    have_free_r      <= have_free_nxt;
    free_at_r        <= free_at_nxt;
    out_found_addr_r <= out_found_addr_nxt;
    out_status_r     <= out_status_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_found_addr = out_found_addr_r;
  assign out_status     = out_status_r;

endmodule

// File: rtl/dcmt_cmp.sv
`timescale 1ns / 1ps

module dcmt_cmp (
  input  logic [dcmt_pkg::ID_W-1:0]   slot_id,
  input  logic [dcmt_pkg::ADDR_W-1:0] slot_addr,
  input  logic [dcmt_pkg::ID_W-1:0]   req_id,
  input  logic [dcmt_pkg::ADDR_W-1:0] req_addr,
  output dcmt_pkg::hit_t              hit
);
  import dcmt_pkg::*;

  always_comb begin
    hit.id_hit   = (slot_id == req_id);
    hit.addr_hit = (slot_addr == req_addr);
    hit.free     = (slot_id == '0);
  end

endmodule

// File: rtl/dcmt_store.sv
`timescale 1ns / 1ps

module dcmt_store #(
  parameter int NUM_CHILDREN = dcmt_pkg::NUM_CHILDREN_DEF,
  parameter int IDX_W        = (NUM_CHILDREN > 1) ? $clog2(NUM_CHILDREN) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_idx,
  output logic                        rd_vld_r,
  output logic [IDX_W-1:0]            rd_idx_r,
  output logic [dcmt_pkg::ID_W-1:0]   rd_id,
  output logic [dcmt_pkg::ADDR_W-1:0] rd_addr,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_idx,
  input  logic [dcmt_pkg::ID_W-1:0]   wr_id,
  input  logic [dcmt_pkg::ADDR_W-1:0] wr_addr
);
  import dcmt_pkg::*;

  logic [ID_W-1:0]         id_mem   [NUM_CHILDREN];
  logic [ADDR_W-1:0]       addr_mem [NUM_CHILDREN];
  logic [NUM_CHILDREN-1:0] valid_r;
  logic                    rd_slot_vld_r;
  logic [ID_W-1:0]         rd_id_r;
  logic [ADDR_W-1:0]       rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_idx]   <= wr_id;
      addr_mem[wr_idx] <= wr_addr;
    end
    if (rd_en) begin
      rd_id_r   <= id_mem[rd_idx];
      rd_addr_r <= addr_mem[rd_idx];
      rd_idx_r  <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      rd_vld_r      <= 1'b0;
      rd_slot_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (rd_en) begin
        rd_slot_vld_r <= valid_r[rd_idx];
      end
      if (clr) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  // A slot that has not been written since the last clear reads as free.
  assign rd_id   = rd_slot_vld_r ? rd_id_r : '0;
  assign rd_addr = rd_slot_vld_r ? rd_addr_r : '0;

endmodule

// File: test/directory_child_map_table_test.sv
`timescale 1ns / 1ps

module directory_child_map_table_test;
  import dcmt_pkg::*;

  localparam int NUM_SLOTS = NUM_CHILDREN_DEF;
  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL_SIZE = 24;

  typedef struct {
    op_t              op;
    logic [ID_W-1:0]   file_id;
    logic [ADDR_W-1:0] target_addr;
    bit               drain;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] found_addr;
    status_t           status;
  } outcome_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_op;
  logic [ID_W-1:0]   in_file_id;
  logic [ADDR_W-1:0] in_target_addr;
  logic              out_strobe;
  logic [ADDR_W-1:0] out_found_addr;
  logic [1:0]        out_status;

  directory_child_map_table #(
    .NUM_CHILDREN(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_file_id(in_file_id),
    .in_target_addr(in_target_addr),
    .out_strobe(out_strobe),
    .out_found_addr(out_found_addr),
    .out_status(out_status)
  );

  request_t pending_reqs[$];
  outcome_t expected_results[$];
  request_t cur_req;
  bit       holding;
  bit       took;
  int       gap_left;
  int       errors;
  int       cycles;

  logic [ID_W-1:0]   slot_id[NUM_SLOTS];
  logic [ADDR_W-1:0] slot_addr[NUM_SLOTS];

  int n_lookups, n_hits, n_clears, n_noops;
  int n_insert[4];

  logic [ID_W-1:0]   id_pool[POOL_SIZE];
  logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Updates the local copy of the table and queues the result it implies.
  function automatic void apply_request(input request_t r);
    outcome_t res;
    int       k;
    int       free_slot;
    bit       clash;
    bit       hit;
    res.found_addr = '0;
    res.status = ST_GOOD;
    free_slot = -1;
    clash = 1'b0;
    hit = 1'b0;
    case (r.op)
      OP_LOOKUP: begin
        n_lookups++;
        if (r.file_id != '0) begin
          for (k = 0; k < NUM_SLOTS; k++) begin
            if (!hit && slot_id[k] == r.file_id) begin
              hit = 1'b1;
              res.found_addr = slot_addr[k];
            end
          end
        end
        if (hit) n_hits++;
      end
      OP_INSERT: begin
        if (r.file_id == '0 || r.target_addr == '0) begin
          res.status = ST_PARAM;
        end else begin
          for (k = 0; k < NUM_SLOTS; k++) begin
            if (slot_id[k] == r.file_id || slot_addr[k] == r.target_addr) clash = 1'b1;
            if (free_slot < 0 && slot_id[k] == '0) free_slot = k;
          end
          if (clash) begin
            res.status = ST_EXISTS;
          end else if (free_slot < 0) begin
            res.status = ST_FULL;
          end else begin
            slot_id[free_slot] = r.file_id;
            slot_addr[free_slot] = r.target_addr;
          end
        end
        n_insert[res.status]++;
      end
      OP_CLEAR: begin
        n_clears++;
        for (k = 0; k < NUM_SLOTS; k++) begin
          slot_id[k] = '0;
          slot_addr[k] = '0;
        end
      end
      default: n_noops++;
    endcase
    expected_results.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_req(input op_t op, input logic [ID_W-1:0] id,
                         input logic [ADDR_W-1:0] addr, input bit drain);
    request_t r;
    r.op = op;
    r.file_id = id;
    r.target_addr = addr;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  // Transaction acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) apply_request(cur_req);
    end
  end

  // Driver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (took) holding = 1'b0;
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && (expected_results.size() != 0 || busy))) begin
          cur_req = pending_reqs.pop_front();
          holding = 1'b1;
          gap_left = pick_gap();
        end
      end
      start <= holding;
      if (holding) begin
        in_op <= cur_req.op;
        in_file_id <= cur_req.file_id;
        in_target_addr <= cur_req.target_addr;
      end else begin
        in_op <= 2'($urandom_range(0, 3));
        in_file_id <= ID_W'($urandom);
        in_target_addr <= $urandom;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    outcome_t exp_res;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result found_addr=%h status=%0d", $time,
                 out_found_addr, out_status);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_found_addr !== exp_res.found_addr) begin
          $display("%0t: found_addr expected %h actual %h", $time,
                   exp_res.found_addr, out_found_addr);
          errors++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_res.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int       k;
    int       ep_len;
    int       insert_pct;
    int       r;
    int       total;
    op_t      op;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = '0;
    in_file_id = '0;
    in_target_addr = '0;
    holding = 1'b0;
    gap_left = 0;
    errors = 0;
    cycles = 0;
    for (k = 0; k < NUM_SLOTS; k++) begin
      slot_id[k] = '0;
      slot_addr[k] = '0;
    end

    add_req(OP_LOOKUP, '0, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_LOOKUP, 16'hFFFF, '0, 1'b0);
    add_req(OP_INSERT, '0, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_INSERT, 16'hFFFF, '0, 1'b0);
    add_req(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_LOOKUP, 16'hFFFF, '0, 1'b0);
    add_req(OP_INSERT, 16'hFFFF, 32'h1234_5678, 1'b0);
    add_req(OP_INSERT, 16'h0001, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    for (k = 1; k < NUM_SLOTS; k++) add_req(OP_INSERT, ID_W'(k), ADDR_W'(k), 1'b0);
    add_req(OP_LOOKUP, ID_W'(NUM_SLOTS - 1), '0, 1'b0);
    add_req(OP_INSERT, 16'h8000, 32'h8000_0000, 1'b0);
    add_req(OP_INSERT, 16'h8000, 32'h0000_0003, 1'b0);
    add_req(OP_CLEAR, '0, '0, 1'b1);
    add_req(OP_LOOKUP, 16'hFFFF, '0, 1'b0);

    // Random part: episodes over small pools of keys so that lookups hit,
    // duplicates collide and the table often fills.
    total = 0;
    while (total < RANDOM_ITEMS) begin
      for (k = 0; k < POOL_SIZE; k++) begin
        id_pool[k] = ID_W'($urandom);
        addr_pool[k] = $urandom;
      end
      if ($urandom_range(0, 4) != 0) begin
        add_req(OP_CLEAR, ID_W'($urandom), $urandom, $urandom_range(0, 3) == 0);
        total++;
      end
      ep_len = $urandom_range(20, 70);
      insert_pct = $urandom_range(40, 75);
      for (k = 0; k < ep_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < insert_pct) op = OP_INSERT;
        else if (r < 95) op = OP_LOOKUP;
        else if (r < 98) op = OP_NONE;
        else op = OP_CLEAR;
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) :
             id_pool[$urandom_range(0, POOL_SIZE - 1)];
        addr = ($urandom_range(0, 9) == 0) ? 32'($urandom) :
               addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 29) == 0) id = '0;
        if ($urandom_range(0, 29) == 0) addr = '0;
        add_req(op, id, addr, 1'b0);
        total++;
      end
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    while (pending_reqs.size() != 0 || holding || expected_results.size() != 0)
      @(posedge clk);
    repeat (NUM_SLOTS + 20) @(posedge clk);

    $display("Ran %0d lookups (%0d hits), %0d clears and %0d no-ops.",
             n_lookups, n_hits, n_clears, n_noops);
    $display("Inserts: %0d good, %0d exists, %0d full, %0d bad parameter.",
             n_insert[ST_GOOD], n_insert[ST_EXISTS], n_insert[ST_FULL],
             n_insert[ST_PARAM]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dcmt_pkg.sv
rtl/dcmt_cmp.sv
rtl/dcmt_store.sv
rtl/directory_child_map_table.sv
test/directory_child_map_table_test.sv
